// ----- rtl/core/lzd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lzd_pkg: shared types and constants of the LZ token stream decoder
// Command and status bundles between controller and datapath, token kinds
// and field widths that do not vary.
// ----------------------------------------------------------------------------
package lzd_pkg;

	localparam int BYTE_W = 8;
	localparam int DIST_W = 16;	// match distance, up to 32768
	localparam int CNT_W  = 16;	// produced byte count, saturating
	localparam int LEN_W  = 7;	// match length, up to 67
	localparam int LIT_W  = 7;	// literal run length
	localparam int BCNT_W = 3;	// bytes in one result

	// Match token kinds
	localparam logic [1:0] KIND_SHORT = 2'd0;	// 10ppppnn
	localparam logic [1:0] KIND_MED   = 2'd1;	// 110ppppp ppppplll
	localparam logic [1:0] KIND_LONG  = 2'd2;	// 111ppppp pppppppp ppnnnnnn

	typedef struct packed {
		logic       lit_load;	// load literal run length from header
		logic       lit_take;	// store and emit one literal byte
		logic       eos;	// emit end of stream, rewind position
		logic       err;	// emit offset error
		logic       acc_first;	// first byte of a multi-byte token
		logic       acc_next;	// middle byte of a long token
		logic [1:0] kind;	// token kind for length and distance decode
		logic       start;	// load match length and source address
		logic       rd;	// read history at source address
		logic       wr;	// write copied byte, advance match
	} lzd_cmd_t;

	typedef struct packed {
		logic out_free;	// output register can take a result this cycle
		logic hdr_zero;
		logic hdr_lit;
		logic hdr_short;
		logic hdr_med;
		logic dist_bad;	// distance reaches before the first byte
		logic lit_last;	// one literal left in the run
		logic len_last;	// one match byte left
		logic slot_full;	// copied byte fills the result
	} lzd_status_t;

endpackage
`default_nettype wire

// ----- rtl/core/lzd_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lzd_ctrl: token parser and match sequencer
// Walks the token phases, handles the input handshake and steps the
// datapath through match copies one read and one write at a time.
// ----------------------------------------------------------------------------
module lzd_ctrl (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  tok_valid,
	output logic                 tok_stall,
	input  lzd_pkg::lzd_status_t st,
	output lzd_pkg::lzd_cmd_t    cmd
);
	import lzd_pkg::*;

	localparam logic [2:0] ST_HEADER     = 3'd0;
	localparam logic [2:0] ST_LITERAL    = 3'd1;
	localparam logic [2:0] ST_SHORT_LAST = 3'd2;
	localparam logic [2:0] ST_LONG_MID   = 3'd3;
	localparam logic [2:0] ST_LONG_LAST  = 3'd4;
	localparam logic [2:0] ST_MREAD      = 3'd5;
	localparam logic [2:0] ST_MWRITE     = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       parse_st;
	logic       take;

	assign parse_st = (state_q == ST_HEADER) || (state_q == ST_LITERAL) ||
		(state_q == ST_SHORT_LAST) || (state_q == ST_LONG_MID) ||
		(state_q == ST_LONG_LAST);
	assign tok_stall = !(parse_st && st.out_free);
	assign take = tok_valid && !tok_stall;

	always_comb begin
		cmd = '0;
		cmd.kind = KIND_SHORT;
		state_d = state_q;
		case (state_q)
			ST_HEADER: begin
				if (take) begin
					if (st.hdr_zero) begin
						cmd.eos = 1'b1;
					end else if (st.hdr_lit) begin
						cmd.lit_load = 1'b1;
						state_d = ST_LITERAL;
					end else if (st.hdr_short) begin
						if (st.dist_bad) begin
							cmd.err = 1'b1;
						end else begin
							cmd.start = 1'b1;
							state_d = ST_MREAD;
						end
					end else if (st.hdr_med) begin
						cmd.acc_first = 1'b1;
						state_d = ST_SHORT_LAST;
					end else begin
						cmd.acc_first = 1'b1;
						state_d = ST_LONG_MID;
					end
				end
			end
			ST_LITERAL: begin
				if (take) begin
					cmd.lit_take = 1'b1;
					if (st.lit_last)
						state_d = ST_HEADER;
				end
			end
			ST_SHORT_LAST: begin
				cmd.kind = KIND_MED;
				if (take) begin
					if (st.dist_bad) begin
						cmd.err = 1'b1;
						state_d = ST_HEADER;
					end else begin
						cmd.start = 1'b1;
						state_d = ST_MREAD;
					end
				end
			end
			ST_LONG_MID: begin
				if (take) begin
					cmd.acc_next = 1'b1;
					state_d = ST_LONG_LAST;
				end
			end
			ST_LONG_LAST: begin
				cmd.kind = KIND_LONG;
				if (take) begin
					if (st.dist_bad) begin
						cmd.err = 1'b1;
						state_d = ST_HEADER;
					end else begin
						cmd.start = 1'b1;
						state_d = ST_MREAD;
					end
				end
			end
			ST_MREAD: begin
				cmd.rd = 1'b1;
				state_d = ST_MWRITE;
			end
			ST_MWRITE: begin
				// hold while a full or final result cannot leave
				if (!(st.slot_full || st.len_last) || st.out_free) begin
					cmd.wr = 1'b1;
					state_d = st.len_last ? ST_HEADER : ST_MREAD;
				end
			end
			default: begin
				state_d = ST_HEADER;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_HEADER;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
`default_nettype wire

// ----- rtl/core/lzd_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lzd_datapath: history memory, stream counters and result register
// Decodes token lengths and distances, keeps the write position and byte
// count, copies match bytes and packs up to four bytes per result.
// ----------------------------------------------------------------------------
module lzd_datapath #(
	parameter int HISTORY_DEPTH = 32768
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  lzd_pkg::lzd_cmd_t    cmd,
	output lzd_pkg::lzd_status_t st,
	input  wire  [7:0]           in_byte,
	input  wire                  res_stall,
	output logic                 res_valid,
	output logic [7:0]           byte0,
	output logic [7:0]           byte1,
	output logic [7:0]           byte2,
	output logic [7:0]           byte3,
	output logic [2:0]           byte_count,
	output logic                 last,
	output logic                 end_of_stream,
	output logic                 offset_error
);
	import lzd_pkg::*;

	localparam int AW = $clog2(HISTORY_DEPTH);
	localparam int SW = ((AW > DIST_W) ? AW : DIST_W) + 1;
	localparam logic [AW-1:0] WRAP = AW'(HISTORY_DEPTH - 1);

	logic [BYTE_W-1:0] hist_mem [HISTORY_DEPTH];
	logic [BYTE_W-1:0] rd_q;
	logic [AW-1:0]     wp_q;
	logic [AW-1:0]     src_q;
	logic [CNT_W-1:0]  produced_q;
	logic [LIT_W-1:0]  lit_left_q;
	logic [15:0]       acc_q;
	logic [LEN_W-1:0]  len_q;
	logic [1:0]        slot_q;
	logic [BYTE_W-1:0] pk_q [4];
	logic              res_valid_q;
	logic [BYTE_W-1:0] res_byte_q [4];
	logic [BCNT_W-1:0] res_cnt_q;
	logic              res_last_q;
	logic              res_eos_q;
	logic              res_err_q;

	logic [LEN_W-1:0]  len_d;
	logic [DIST_W-1:0] dist_d;
	logic [SW-1:0]     diff;
	logic [AW-1:0]     src_d;
	logic [AW-1:0]     src_next;
	logic [AW-1:0]     wp_next;
	logic [CNT_W-1:0]  produced_next;
	logic              byte_wr;
	logic [BYTE_W-1:0] wdata;
	logic              match_emit;
	logic              emit_any;
	logic [BYTE_W-1:0] lane_d [4];
	logic [BCNT_W-1:0] cnt_d;
	logic              last_d;

	// Token length and distance
	always_comb begin
		case (cmd.kind)
			KIND_MED: begin
				len_d  = LEN_W'(in_byte[2:0]) + LEN_W'(3);
				dist_d = DIST_W'({acc_q[4:0], in_byte[7:3]}) + DIST_W'(1);
			end
			KIND_LONG: begin
				len_d  = LEN_W'(in_byte[5:0]) + LEN_W'(4);
				dist_d = DIST_W'({acc_q[12:0], in_byte[7:6]}) + DIST_W'(1);
			end
			default: begin
				len_d  = LEN_W'(in_byte[1:0]) + LEN_W'(2);
				dist_d = DIST_W'(in_byte[5:2]) + DIST_W'(1);
			end
		endcase
	end

	// Source start: write position minus distance, wrapped into the history
	assign diff  = SW'(wp_q) - SW'(dist_d);
	assign src_d = diff[SW-1] ? AW'(diff + SW'(HISTORY_DEPTH)) : AW'(diff);

	assign src_next = (src_q == WRAP) ? '0 : src_q + AW'(1);
	assign wp_next  = (wp_q == WRAP) ? '0 : wp_q + AW'(1);
	assign produced_next = (produced_q == '1) ? produced_q : produced_q + CNT_W'(1);

	assign byte_wr    = cmd.lit_take || cmd.wr;
	assign wdata      = cmd.lit_take ? in_byte : rd_q;
	assign match_emit = (slot_q == 2'd3) || (len_q == LEN_W'(1));
	assign emit_any   = cmd.lit_take || cmd.eos || cmd.err || (cmd.wr && match_emit);

	assign st.out_free  = !res_valid_q || !res_stall;
	assign st.hdr_zero  = (in_byte == 8'h00);
	assign st.hdr_lit   = !in_byte[7] && (in_byte != 8'h00);
	assign st.hdr_short = (in_byte[7:6] == 2'b10);
	assign st.hdr_med   = (in_byte[7:5] == 3'b110);
	assign st.dist_bad  = (dist_d > produced_q);
	assign st.lit_last  = (lit_left_q == LIT_W'(1));
	assign st.len_last  = (len_q == LEN_W'(1));
	assign st.slot_full = (slot_q == 2'd3);

	// Next result fields
	always_comb begin
		for (int i = 0; i < 4; i++)
			lane_d[i] = '0;
		cnt_d  = '0;
		last_d = 1'b1;
		if (cmd.lit_take) begin
			lane_d[0] = in_byte;
			cnt_d = BCNT_W'(1);
		end else if (cmd.wr) begin
			for (int i = 0; i < 4; i++) begin
				if (2'(i) == slot_q)
					lane_d[i] = rd_q;
				else if (2'(i) < slot_q)
					lane_d[i] = pk_q[i];
			end
			cnt_d  = BCNT_W'(slot_q) + BCNT_W'(1);
			last_d = (len_q == LEN_W'(1));
		end
	end

	// History memory
	always_ff @(posedge clk) begin
		if (byte_wr)
			hist_mem[wp_q] <= wdata;
		if (cmd.rd)
			rd_q <= hist_mem[src_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q        <= '0;
			produced_q  <= '0;
			lit_left_q  <= '0;
			len_q       <= '0;
			slot_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (cmd.eos) begin
				wp_q       <= '0;
				produced_q <= '0;
			end else if (byte_wr) begin
				wp_q       <= wp_next;
				produced_q <= produced_next;
			end
			if (cmd.eos)
				lit_left_q <= '0;
			else if (cmd.lit_load)
				lit_left_q <= in_byte[LIT_W-1:0];
			else if (cmd.lit_take)
				lit_left_q <= lit_left_q - LIT_W'(1);
			if (cmd.start) begin
				len_q  <= len_d;
				slot_q <= '0;
			end else if (cmd.wr) begin
				len_q  <= len_q - LEN_W'(1);
				slot_q <= match_emit ? 2'd0 : slot_q + 2'd1;
			end
			if (emit_any)
				res_valid_q <= 1'b1;
			else if (!res_stall)
				res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.acc_first)
			acc_q <= {8'h00, in_byte};
		else if (cmd.acc_next)
			acc_q <= {acc_q[7:0], in_byte};
		if (cmd.start)
			src_q <= src_d;
		else if (cmd.wr)
			src_q <= src_next;
		if (cmd.wr)
			pk_q[slot_q] <= rd_q;
		if (emit_any) begin
			res_byte_q <= lane_d;
			res_cnt_q  <= cnt_d;
			res_last_q <= last_d;
			res_eos_q  <= cmd.eos;
			res_err_q  <= cmd.err;
		end
	end

	assign res_valid     = res_valid_q;
	assign byte0         = res_byte_q[0];
	assign byte1         = res_byte_q[1];
	assign byte2         = res_byte_q[2];
	assign byte3         = res_byte_q[3];
	assign byte_count    = res_cnt_q;
	assign last          = res_last_q;
	assign end_of_stream = res_eos_q;
	assign offset_error  = res_err_q;

endmodule
`default_nettype wire

// ----- rtl/core/lz_token_stream_decoder.sv -----
// Timing: a literal, end-of-stream or offset-error result is in the output register
// in the cycle after its byte is taken; each match byte takes a history read, then a
// write, and the input is held until the last match byte is written, through any output stalls.
// Throughput: one token byte per cycle outside matches while the output register is free.
// Reset: arst_n clears parser state, position, count and output valid at once; the
// history is not cleared, reads never reach bytes not written in the current stream.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lz_token_stream_decoder: LZ77 byte token decompressor
// Parses literal runs and three sizes of match token from a byte stream and
// emits decompressed bytes, up to four per result, from a history memory.
// ----------------------------------------------------------------------------
module lz_token_stream_decoder #(
	parameter int HISTORY_DEPTH = 32768	// history bytes, 32768 to 65536
) (
	input  wire        clk,
	input  wire        arst_n,
	// compressed byte channel
	input  wire        tok_valid,
	output logic       tok_stall,
	input  wire  [7:0] in_byte,
	// result channel
	output logic       res_valid,
	input  wire        res_stall,
	output logic [7:0] byte0,
	output logic [7:0] byte1,
	output logic [7:0] byte2,
	output logic [7:0] byte3,
	output logic [2:0] byte_count,
	output logic       last,
	output logic       end_of_stream,
	output logic       offset_error
);
	import lzd_pkg::*;

	// Command and status between the sequencer and the datapath
	lzd_cmd_t    cmd;
	lzd_status_t st;

	// Parser and match sequencer. It takes a transfer only in a parse phase
	// and only when the output register is free or drains this cycle, so every
	// result a byte causes has room. During a match it holds the input.
	lzd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.tok_valid (tok_valid),
		.tok_stall (tok_stall),
		.st        (st),
		.cmd       (cmd)
	);

	// History memory, position and count registers, result register.
	// A distance beyond the bytes produced in this stream yields a flag
	// result and no copy; distances never exceed the history depth.
	lzd_datapath #(
		.HISTORY_DEPTH (HISTORY_DEPTH)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.st            (st),
		.in_byte       (in_byte),
		.res_stall     (res_stall),
		.res_valid     (res_valid),
		.byte0         (byte0),
		.byte1         (byte1),
		.byte2         (byte2),
		.byte3         (byte3),
		.byte_count    (byte_count),
		.last          (last),
		.end_of_stream (end_of_stream),
		.offset_error  (offset_error)
	);

endmodule
`default_nettype wire

// ----- rtl/core/lzd_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lzd_port_assert: port checks for the LZ token stream decoder
// Result packing and flag rules seen on the output channel.
// ----------------------------------------------------------------------------
module lzd_port_assert (
	input wire       clk,
	input wire       arst_n,
	input wire       res_valid,
	input wire       res_stall,
	input wire [7:0] byte0,
	input wire [7:0] byte1,
	input wire [7:0] byte2,
	input wire [7:0] byte3,
	input wire [2:0] byte_count,
	input wire       last,
	input wire       end_of_stream,
	input wire       offset_error
);

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> byte_count <= 3'd4)
		else $error("byte_count above four");

	a_flag_empty: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (end_of_stream || offset_error) |->
			byte_count == 3'd0 && last && !(end_of_stream && offset_error))
		else $error("flag result carries bytes or is not last");

	a_partial_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !last |-> byte_count == 3'd4)
		else $error("non-final result not full");

	a_unused_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && byte_count < 3'd4 |->
			byte3 == 8'h00 && (byte_count >= 3'd3 || byte2 == 8'h00) &&
			(byte_count >= 3'd2 || byte1 == 8'h00) &&
			(byte_count >= 3'd1 || byte0 == 8'h00))
		else $error("byte beyond byte_count not zero");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(byte0) &&
			$stable(byte_count) && $stable(last))
		else $error("stalled result changed");

endmodule

bind lz_token_stream_decoder lzd_port_assert u_lzd_port_assert (
	.clk           (clk),
	.arst_n        (arst_n),
	.res_valid     (res_valid),
	.res_stall     (res_stall),
	.byte0         (byte0),
	.byte1         (byte1),
	.byte2         (byte2),
	.byte3         (byte3),
	.byte_count    (byte_count),
	.last          (last),
	.end_of_stream (end_of_stream),
	.offset_error  (offset_error)
);
`default_nettype wire
